// ----- sv/pkfk_pkg.sv -----
// pkfk_pkg: shared types, opcodes and default sizes for the key-join probe.
// Used by every module of the block; has no dependencies.
`default_nettype none

package pkfk_pkg;

	// defaults for the top-level parameters
	localparam int TABLE_ROWS_DEF   = 1024;
	localparam int PAYLOAD_COLS_DEF = 4;
	localparam int KEY_BITS_DEF     = 32;

	// payload columns that exist on the ports
	localparam int IO_COLS = 4;

	typedef logic [1:0] op_t;
	localparam op_t OP_CLEAR = 2'd0;
	localparam op_t OP_LOAD  = 2'd1;
	localparam op_t OP_PROBE = 2'd2;

	typedef struct packed {
		op_t         op;
		logic [31:0] join_key;
		logic        row_dummy;
		logic [31:0] payload_a;
		logic [31:0] payload_b;
		logic [31:0] payload_c;
		logic [31:0] payload_d;
	} item_t;

	typedef struct packed {
		logic [31:0] joined_a;
		logic [31:0] joined_b;
		logic [31:0] joined_c;
		logic [31:0] joined_d;
		logic        any_match;
		logic        out_dummy;
		logic        load_overflow;
	} result_t;

	// controller -> datapath
	typedef struct packed {
		logic clear;   // empty the table
		logic load;    // append the input row (dropped when full)
		logic start;   // latch probe key, clear sums, rewind scan address
		logic issue;   // read one stored row
		logic finish;  // move the sums into the result register
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic issue_done;   // every loaded row has been read
		logic pipe_busy;    // reads still in flight
		logic result_busy;  // result register holds an untaken word
	} status_t;

endpackage

`default_nettype wire

// ----- sv/pkfk_ctrl.sv -----
// pkfk_ctrl: sequencer for clear, load and probe words.
// Depends on pkfk_pkg (cmd_t, status_t, opcodes).
`default_nettype none

module pkfk_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              item_valid,
	output logic                   item_ready,
	input  wire pkfk_pkg::op_t     op,
	input  wire logic              result_ready,
	input  wire pkfk_pkg::status_t status,
	output pkfk_pkg::cmd_t         cmd
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SCAN  = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;

	assign item_ready = (state_q == ST_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					unique case (op)
						pkfk_pkg::OP_CLEAR: cmd.clear = 1'b1;
						pkfk_pkg::OP_LOAD:  cmd.load  = 1'b1;
						pkfk_pkg::OP_PROBE: begin
							cmd.start = 1'b1;
							state_d   = ST_SCAN;
						end
						default: ;
					endcase
				end
			end
			ST_SCAN: begin
				if (status.issue_done) begin
					state_d = ST_DRAIN;
				end else begin
					cmd.issue = 1'b1;
				end
			end
			ST_DRAIN: begin
				if (!status.pipe_busy && (!status.result_busy || result_ready)) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

// ----- sv/pkfk_datapath.sv -----
// pkfk_datapath: row memory, scan pipeline, column sums and result register.
// Depends on pkfk_pkg (item_t, result_t, cmd_t, status_t).
`default_nettype none

module pkfk_datapath #(
	parameter int TABLE_ROWS   = pkfk_pkg::TABLE_ROWS_DEF,
	parameter int PAYLOAD_COLS = pkfk_pkg::PAYLOAD_COLS_DEF,
	parameter int KEY_BITS     = pkfk_pkg::KEY_BITS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire pkfk_pkg::item_t   item,
	input  wire pkfk_pkg::cmd_t    cmd,
	input  wire logic              result_ready,
	output pkfk_pkg::status_t      status,
	output logic                   result_valid,
	output pkfk_pkg::result_t      result
);

	localparam int CW   = $clog2(TABLE_ROWS + 1);
	localparam int AW   = (TABLE_ROWS > 1) ? $clog2(TABLE_ROWS) : 1;
	localparam int KW   = (KEY_BITS < 32) ? KEY_BITS : 32;   // input key is 32 bits
	localparam int NCOL = (PAYLOAD_COLS < pkfk_pkg::IO_COLS) ? PAYLOAD_COLS
	                                                          : pkfk_pkg::IO_COLS;

	// stored rows: {dummy, key} and the visible payload columns
	logic [KW:0]            row_mem [TABLE_ROWS];
	logic [NCOL-1:0][31:0]  pay_mem [TABLE_ROWS];

	logic [CW-1:0] rows_q;
	logic          ovf_q;
	logic [CW-1:0] addr_q;
	logic [KW-1:0] key_q;
	logic          pdummy_q;

	logic                   vld_s1;
	logic [KW-1:0]          key_s1;
	logic                   dmy_s1;
	logic [NCOL-1:0][31:0]  pay_s1;
	logic                   vld_s2;
	logic                   hit_s2;
	logic [NCOL-1:0][31:0]  pay_s2;

	logic [NCOL-1:0][31:0]  acc_q;
	logic                   any_q;
	logic                   result_valid_q;
	pkfk_pkg::result_t      result_q;

	logic                                full;
	logic [pkfk_pkg::IO_COLS-1:0][31:0]  pay_in;
	logic [pkfk_pkg::IO_COLS-1:0][31:0]  sums;

	assign full   = (rows_q == CW'(TABLE_ROWS));
	assign pay_in = {item.payload_d, item.payload_c, item.payload_b, item.payload_a};

	always_comb begin
		sums = '0;
		for (int c = 0; c < NCOL; c++) begin
			sums[c] = acc_q[c];
		end
	end

	assign status.issue_done  = (addr_q == rows_q);
	assign status.pipe_busy   = vld_s1 | vld_s2;
	assign status.result_busy = result_valid_q;

	assign result_valid = result_valid_q;
	assign result       = result_q;

	// memory write / read
	always_ff @(posedge clk) begin
		if (cmd.load && !full) begin
			row_mem[rows_q[AW-1:0]] <= {item.row_dummy, item.join_key[KW-1:0]};
			pay_mem[rows_q[AW-1:0]] <= pay_in[NCOL-1:0];
		end
		if (cmd.issue) begin
			{dmy_s1, key_s1} <= row_mem[addr_q[AW-1:0]];
			pay_s1           <= pay_mem[addr_q[AW-1:0]];
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q         <= '0;
			ovf_q          <= 1'b0;
			addr_q         <= '0;
			vld_s1         <= 1'b0;
			vld_s2         <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (cmd.clear) begin
				rows_q <= '0;
			end else if (cmd.load) begin
				if (full) begin
					ovf_q <= 1'b1;
				end else begin
					rows_q <= rows_q + CW'(1);
				end
			end
			if (cmd.start) begin
				addr_q <= '0;
			end else if (cmd.issue) begin
				addr_q <= addr_q + CW'(1);
			end
			vld_s1 <= cmd.issue;
			vld_s2 <= vld_s1;
			if (cmd.finish) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	// compare, accumulate, result capture
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			key_q    <= item.join_key[KW-1:0];
			pdummy_q <= item.row_dummy;
		end
		hit_s2 <= !pdummy_q && !dmy_s1 && (key_s1 == key_q);
		pay_s2 <= pay_s1;
		if (cmd.start) begin
			acc_q <= '0;
			any_q <= 1'b0;
		end else if (vld_s2 && hit_s2) begin
			for (int c = 0; c < NCOL; c++) begin
				acc_q[c] <= acc_q[c] + pay_s2[c];
			end
			any_q <= 1'b1;
		end
		if (cmd.finish) begin
			result_q.joined_a      <= sums[0];
			result_q.joined_b      <= sums[1];
			result_q.joined_c      <= sums[2];
			result_q.joined_d      <= sums[3];
			result_q.any_match     <= any_q;
			result_q.out_dummy     <= pdummy_q | !any_q;
			result_q.load_overflow <= ovf_q;
		end
	end

	a_rows_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rows_q <= CW'(TABLE_ROWS))
		else $error("row count beyond table size");

	a_ovf_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		ovf_q |=> ovf_q)
		else $error("overflow flag dropped");

	a_issue_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.issue |-> (addr_q < rows_q))
		else $error("read past loaded rows");

	a_finish_drained: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> (!vld_s1 && !vld_s2))
		else $error("result captured with reads in flight");

endmodule

`default_nettype wire

// ----- sv/pk_fk_equijoin_probe_top.sv -----
// pk_fk_equijoin_probe_top: primary-key / foreign-key join probe, top level.
// Depends on pkfk_pkg, pkfk_ctrl and pkfk_datapath.
//
// Takes one word at a time on the item channel. A clear word empties the
// table, a load word appends one primary-key row (key, dummy flag, payload
// columns) and a probe word scans every loaded row and returns one result
// word: per column the wrapping 32-bit sum of the payloads of rows whose key
// equals the probe key (neither side dummy), a matched flag, the output
// dummy flag (probe dummy or no match) and the sticky overflow flag, set
// when a load found the table full. Clear and load make no result. In a
// probe the scan reads one stored row per cycle through the single read port
// of the row memory, then two pipeline stages (compare, accumulate) drain
// before the result register is loaded. The result register decouples the
// output: loads and clears are still taken while a result word waits, and
// a finished probe waits only if the previous result has not been taken.
// Stored rows need no clearing pass; only rows below the load count are
// ever read.
`default_nettype none

module pk_fk_equijoin_probe_top #(
	parameter int TABLE_ROWS   = pkfk_pkg::TABLE_ROWS_DEF,
	parameter int PAYLOAD_COLS = pkfk_pkg::PAYLOAD_COLS_DEF,
	parameter int KEY_BITS     = pkfk_pkg::KEY_BITS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              item_valid,
	output logic                   item_ready,
	input  wire pkfk_pkg::item_t   item,
	output logic                   result_valid,
	input  wire logic              result_ready,
	output pkfk_pkg::result_t      result
);

	pkfk_pkg::cmd_t    cmd;
	pkfk_pkg::status_t status;

	// sequencer: accepts words only when idle, runs the scan
	pkfk_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.op           (item.op),
		.result_ready (result_ready),
		.status       (status),
		.cmd          (cmd)
	);

	// table memory, compare/sum pipeline, result register
	pkfk_datapath #(
		.TABLE_ROWS   (TABLE_ROWS),
		.PAYLOAD_COLS (PAYLOAD_COLS),
		.KEY_BITS     (KEY_BITS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.cmd          (cmd),
		.result_ready (result_ready),
		.status       (status),
		.result_valid (result_valid),
		.result       (result)
	);

endmodule

`default_nettype wire
